// ----- sv/gww_pkg.sv -----
// Shared types and constants for the greedy word-wrap line breaker.
package gww_pkg;

    localparam int MAX_LINES = 64;
    localparam int MAX_CHARS = 4096;

    localparam int POS_W   = 13;
    localparam int CNT_W   = 7;
    localparam int RUN_W   = 13;
    localparam int WORD_W  = 16;
    localparam int GLYPH_W = 8;
    localparam int CODE_W  = 16;
    localparam int CFG_W   = 12;
    localparam int SBW_W   = 8;
    localparam int IDX_W   = 6;
    localparam int LH_W    = 9;
    localparam int PAGE_W  = 11;
    localparam int DCNT_W  = 4;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [7:0]        CODE_SPACE   = 8'h20;
    localparam logic [7:0]        CODE_NEWLINE = 8'h0A;
    localparam logic [LH_W-1:0]   LINE_GAP     = 9'd2;
    localparam logic [RUN_W-1:0]  RUN_MAX      = 13'h1FFF;
    localparam logic [WORD_W-1:0] WORD_MAX     = 16'hFFFF;

    localparam logic OP_CHAR      = 1'b0;
    localparam logic OP_FINISH    = 1'b1;
    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        REG_AREA_WIDTH      = 2'd0,
        REG_WINDOW_HEIGHT   = 2'd1,
        REG_SCROLLBAR_ON    = 2'd2,
        REG_SCROLLBAR_WIDTH = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SUM  = 3'b100
    } t_state;

    typedef struct packed {
        logic               op;
        logic [CODE_W-1:0]  char_code;
        logic [GLYPH_W-1:0] glyph_width;
        logic [GLYPH_W-1:0] glyph_height;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  line_index;
        logic [POS_W-1:0]  line_begin;
        logic [POS_W-1:0]  line_end;
        logic [CNT_W-1:0]  total_lines;
        logic [LH_W-1:0]   line_height;
        logic [PAGE_W-1:0] page_size;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] area_width;
        logic [CFG_W-1:0] window_height;
        logic             scrollbar_on;
        logic [SBW_W-1:0] scrollbar_width;
    } t_cfg;

    typedef struct packed {
        logic char_go;
        logic fin_go;
        logic div_step;
        logic sum_load;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic div_last;
    } t_sts;

endpackage

// ----- sv/gww_ctrl.sv -----
// Controller: input handshake and finish sequencing (divide, then summary).
module gww_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_op,
    input  gww_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output gww_pkg::t_cmd  o_cmd
);
    import gww_pkg::*;

    t_state r_state, n_state;
    logic   fire;

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE) && i_sts.slot_free;
        fire           = i_in_valid && o_in_ready;
        o_cmd.char_go  = fire && (i_op == OP_CHAR);
        o_cmd.fin_go   = fire && (i_op == OP_FINISH);
        o_cmd.div_step = 1'b0;
        o_cmd.sum_load = 1'b0;
        n_state        = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.fin_go) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                // summary waits for the line record ahead of it to leave
                if (i_sts.slot_free) begin
                    o_cmd.sum_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/gww_dp.sv -----
// Datapath: wrap state, line break decision, page-size divider, output register.
module gww_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gww_pkg::t_cfg      i_cfg,
    input  gww_pkg::t_in_item  i_item,
    input  gww_pkg::t_cmd      i_cmd,
    output gww_pkg::t_sts      o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output gww_pkg::t_out_item o_out_data
);
    import gww_pkg::*;

    logic [POS_W-1:0]   r_pos, r_start, r_sp_pos;
    logic [CNT_W-1:0]   r_count;
    logic [RUN_W-1:0]   r_run;
    logic [WORD_W-1:0]  r_word;
    logic               r_sp_seen, r_inw, r_stopped;
    logic [GLYPH_W-1:0] r_tall;

    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [CNT_W-1:0]   r_sum_total;
    logic [LH_W-1:0]    r_sum_lh;
    logic [LH_W-1:0]    r_rem;
    logic [CFG_W-1:0]   r_quo;
    logic [DCNT_W-1:0]  r_div_cnt;

    logic               active, is_ascii, is_sp, is_nl;
    logic               sp_seen1, inw1, over, brk_space;
    logic [POS_W-1:0]   sp_pos1, brk_end, pos_inc;
    logic [CNT_W-1:0]   count_inc;
    logic [WORD_W-1:0]  word_base, word1;
    logic [WORD_W:0]    word_sum;
    logic [RUN_W:0]     run_sum;
    logic [RUN_W-1:0]   run1, run_brk;
    logic signed [RUN_W:0] maxw;
    logic [GLYPH_W-1:0] tall1;
    logic [LH_W-1:0]    lh_new;
    logic [LH_W:0]      trial;
    logic               trial_ge;

    always_comb begin
        active    = !r_stopped && (r_pos < POS_W'(MAX_CHARS));
        is_ascii  = (i_item.char_code[15:8] == 8'd0);
        is_sp     = is_ascii && (i_item.char_code[7:0] == CODE_SPACE);
        is_nl     = is_ascii && (i_item.char_code[7:0] == CODE_NEWLINE);
        pos_inc   = r_pos + POS_W'(1);
        count_inc = r_count + CNT_W'(1);

        sp_seen1  = is_sp ? 1'b1 : r_sp_seen;
        sp_pos1   = is_sp ? r_pos : r_sp_pos;
        inw1      = is_sp ? 1'b1 : (is_ascii ? r_inw : 1'b0);
        tall1     = (i_item.glyph_height > r_tall) ? i_item.glyph_height : r_tall;

        // word width restarts at a space, the space itself counted
        word_base = is_sp ? '0 : r_word;
        word_sum  = {1'b0, word_base} + {{(WORD_W+1-GLYPH_W){1'b0}}, i_item.glyph_width};
        if (!inw1) begin
            word1 = word_base;
        end else if (word_sum[WORD_W]) begin
            word1 = WORD_MAX;
        end else begin
            word1 = word_sum[WORD_W-1:0];
        end

        run_sum = {1'b0, r_run} + {{(RUN_W+1-GLYPH_W){1'b0}}, i_item.glyph_width};
        run1    = run_sum[RUN_W] ? RUN_MAX : run_sum[RUN_W-1:0];

        // usable width goes negative when the scrollbar is on and wider than the area
        maxw = signed'({2'b00, i_cfg.area_width})
             - signed'({6'b000000, (i_cfg.scrollbar_on ? i_cfg.scrollbar_width : 8'd0)});
        over = signed'({1'b0, run1}) > maxw;

        brk_space = inw1 && sp_seen1 && (sp_pos1 != r_pos);
        brk_end   = brk_space ? (sp_pos1 + POS_W'(1)) : r_pos;
        if (!brk_space) begin
            run_brk = {{(RUN_W-GLYPH_W){1'b0}}, i_item.glyph_width};
        end else if (word1 > {{(WORD_W-RUN_W){1'b0}}, RUN_MAX}) begin
            run_brk = RUN_MAX;
        end else begin
            run_brk = word1[RUN_W-1:0];
        end

        lh_new = {1'b0, r_tall} + LINE_GAP;

        trial    = {r_rem, r_quo[CFG_W-1]};
        trial_ge = trial >= {1'b0, r_sum_lh};
    end

    // wrap state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.fin_go) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_start   <= '0;
            r_run     <= '0;
            r_word    <= '0;
            r_sp_seen <= 1'b0;
            r_sp_pos  <= '0;
            r_inw     <= 1'b0;
            r_tall    <= '0;
            r_stopped <= 1'b0;
        end else if (i_cmd.char_go && active) begin
            r_pos <= pos_inc;
            if (is_nl) begin
                r_sp_seen <= 1'b0;
                r_run     <= '0;
                r_inw     <= 1'b1;
                r_count   <= count_inc;
                r_start   <= pos_inc;
                r_stopped <= count_inc >= CNT_W'(MAX_LINES - 1);
            end else begin
                r_tall <= tall1;
                r_word <= word1;
                if (over) begin
                    r_run     <= run_brk;
                    r_count   <= count_inc;
                    r_start   <= brk_end;
                    r_stopped <= count_inc >= CNT_W'(MAX_LINES - 1);
                    r_sp_seen <= 1'b0;
                    r_sp_pos  <= sp_pos1;
                    r_inw     <= 1'b0;
                end else begin
                    r_run     <= run1;
                    r_sp_seen <= sp_seen1;
                    r_sp_pos  <= sp_pos1;
                    r_inw     <= inw1;
                end
            end
        end
    end

    // restoring divider: window height / line height, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.fin_go) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_go) begin
            r_rem       <= '0;
            r_quo       <= i_cfg.window_height;
            r_sum_lh    <= lh_new;
            r_sum_total <= count_inc;
        end else if (i_cmd.div_step) begin
            if (trial_ge) begin
                r_rem <= LH_W'(trial - {1'b0, r_sum_lh});
            end else begin
                r_rem <= trial[LH_W-1:0];
            end
            r_quo <= {r_quo[CFG_W-2:0], trial_ge};
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (i_cmd.char_go && active && (is_nl || over)) begin
            n_out_valid      = 1'b1;
            n_out            = '0;
            n_out.kind       = KIND_LINE;
            n_out.line_index = r_count[IDX_W-1:0];
            n_out.line_begin = r_start;
            n_out.line_end   = is_nl ? r_pos : brk_end;
            n_out.last       = 1'b1;
        end else if (i_cmd.fin_go) begin
            n_out_valid      = 1'b1;
            n_out            = '0;
            n_out.kind       = KIND_LINE;
            n_out.line_index = r_count[IDX_W-1:0];
            n_out.line_begin = r_start;
            n_out.line_end   = r_pos;
            n_out.last       = 1'b0;
        end else if (i_cmd.sum_load) begin
            n_out_valid       = 1'b1;
            n_out             = '0;
            n_out.kind        = KIND_SUMMARY;
            n_out.total_lines = r_sum_total;
            n_out.line_height = r_sum_lh;
            n_out.page_size   = r_quo[PAGE_W-1:0];
            n_out.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_sts.div_last  = (r_div_cnt == DCNT_W'(CFG_W - 1));
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// ----- sv/greedy_word_wrap_line_breaker.sv -----
// Greedy word-wrap line breaker: registers, controller and datapath.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction per
// character, or a finish transaction that closes the content.
// Output channel (o_out_valid / i_out_ready / o_out_data): line records and,
// after a finish, a summary with line count, line height and page size.
// A character that closes a line produces its record in the cycle after it is
// accepted; other characters produce nothing. Characters are accepted one
// per cycle while the output register is empty or being drained.
// A finish puts the last line record out the next cycle, then runs a
// restoring divider (one quotient bit per cycle) for the page size; the
// summary follows once the output register is free, and the next
// transaction is taken only after the summary has been loaded.
// When the receiver stalls, the single output register holds its record and
// o_in_ready drops until it is taken. Reset (synchronous, active low) clears
// all wrap state and restores the configuration defaults: area width 240,
// window height 320, scrollbar on, scrollbar width 8. The user must write the
// APB port only while the block is idle; the block does not enforce it.
module greedy_word_wrap_line_breaker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  gww_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output gww_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gww_pkg::APB_AW-1:0]  paddr,
    input  logic [gww_pkg::APB_DW-1:0]  pwdata,
    output logic [gww_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import gww_pkg::*;

    t_cfg     r_cfg;
    t_cmd     cmd;
    t_sts     sts;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_width      <= 12'd240;
            r_cfg.window_height   <= 12'd320;
            r_cfg.scrollbar_on    <= 1'b1;
            r_cfg.scrollbar_width <= 8'd8;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_AREA_WIDTH:      r_cfg.area_width      <= pwdata[CFG_W-1:0];
                REG_WINDOW_HEIGHT:   r_cfg.window_height   <= pwdata[CFG_W-1:0];
                REG_SCROLLBAR_ON:    r_cfg.scrollbar_on    <= pwdata[0];
                REG_SCROLLBAR_WIDTH: r_cfg.scrollbar_width <= pwdata[SBW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_AREA_WIDTH:      prdata = APB_DW'(r_cfg.area_width);
            REG_WINDOW_HEIGHT:   prdata = APB_DW'(r_cfg.window_height);
            REG_SCROLLBAR_ON:    prdata = APB_DW'(r_cfg.scrollbar_on);
            REG_SCROLLBAR_WIDTH: prdata = APB_DW'(r_cfg.scrollbar_width);
            default:             prdata = '0;
        endcase
    end

    gww_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    gww_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a summary always ends the finish transaction's results
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == KIND_SUMMARY) |-> o_out_data.last)
        else $error("summary without last flag");

    // only the line record ahead of a summary carries last low
    a_notlast_is_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> (o_out_data.kind == KIND_LINE))
        else $error("non-final result is not a line record");

    // the divider runs right after a finish, so no input is taken then
    a_finish_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.op == OP_FINISH) |=> !o_in_ready)
        else $error("input taken while page size is being computed");

endmodule

// ----- verif/greedy_word_wrap_line_breaker_tb.sv -----
// Self-checking testbench for the greedy word-wrap line breaker.
module greedy_word_wrap_line_breaker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gww_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 24;
    localparam int DIR_N       = 19;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 76;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        t_in_item  item;
        int        n_typed;
        t_out_item typed0;
        t_out_item typed1;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // typed expectations travel with the item so they are sampled with it
    int                   drv_typed_n;
    t_out_item            drv_typed0;
    t_out_item            drv_typed1;

    // predictor copy of the wrap state and the registers
    t_cfg                 cfg_now;
    logic [POS_W-1:0]     next_pos;
    logic [POS_W-1:0]     line_open_at;
    logic [POS_W-1:0]     space_at;
    logic [CNT_W-1:0]     lines_done;
    logic [RUN_W-1:0]     line_px;
    logic [WORD_W-1:0]    word_px;
    logic                 space_on_line;
    logic                 word_run_on;
    logic                 halted;
    logic [GLYPH_W-1:0]   tallest;

    t_out_item            fresh_records [$];
    t_out_item            expected_records [$];

    int                   mismatches;
    int                   idle_cycles;
    logic                 steady;
    int                   hold_asked;
    int                   hold_served;
    int                   hold_left;
    t_dir_row             dir_table [DIR_N];

    greedy_word_wrap_line_breaker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void wrap_clear();
        next_pos      = '0;
        line_open_at  = '0;
        space_at      = '0;
        lines_done    = '0;
        line_px       = '0;
        word_px       = '0;
        space_on_line = 1'b0;
        word_run_on   = 1'b0;
        halted        = 1'b0;
        tallest       = '0;
    endfunction

    function automatic t_out_item line_record(int idx, int lbeg, int lend, logic lst);
        t_out_item r;
        r            = '0;
        r.kind       = KIND_LINE;
        r.line_index = IDX_W'(idx);
        r.line_begin = POS_W'(lbeg);
        r.line_end   = POS_W'(lend);
        r.last       = lst;
        return r;
    endfunction

    function automatic t_out_item summary_record(int total, int lh, int page);
        t_out_item r;
        r             = '0;
        r.kind        = KIND_SUMMARY;
        r.total_lines = CNT_W'(total);
        r.line_height = LH_W'(lh);
        r.page_size   = PAGE_W'(page);
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic void close_wrap_line(int lend, int next_start);
        fresh_records.push_back(line_record(lines_done, line_open_at, lend, 1'b1));
        lines_done   = lines_done + 1'b1;
        line_open_at = POS_W'(next_start);
        if (int'(lines_done) >= MAX_LINES - 1) halted = 1'b1;
    endfunction

    // Expected records for one accepted transaction, left in fresh_records.
    function automatic void predict_wrap(t_in_item it);
        int p;
        int px;
        int wpx;
        int maxw;
        int lh;
        int brk;
        p = int'(next_pos);
        fresh_records.delete();
        if (it.op == OP_FINISH) begin
            lh = int'(tallest) + int'(LINE_GAP);
            fresh_records.push_back(line_record(lines_done, line_open_at, p, 1'b0));
            lines_done = lines_done + 1'b1;
            fresh_records.push_back(summary_record(lines_done, lh,
                                                   int'(cfg_now.window_height) / lh));
            wrap_clear();
            return;
        end
        if (halted || p >= MAX_CHARS) return;
        if (it.char_code[15:8] == 8'h00) begin
            if (it.char_code[7:0] == CODE_SPACE) begin
                space_on_line = 1'b1;
                space_at      = POS_W'(p);
                word_run_on   = 1'b1;
                word_px       = '0;
            end else if (it.char_code[7:0] == CODE_NEWLINE) begin
                // no width, no height; the word width carries over
                space_on_line = 1'b0;
                line_px       = '0;
                word_run_on   = 1'b1;
                close_wrap_line(p, p + 1);
                next_pos = POS_W'(p + 1);
                return;
            end
        end else begin
            word_run_on = 1'b0;
        end
        if (it.glyph_height > tallest) tallest = it.glyph_height;
        if (word_run_on) begin
            wpx     = int'(word_px) + int'(it.glyph_width);
            word_px = (wpx > int'(WORD_MAX)) ? WORD_MAX : WORD_W'(wpx);
        end
        px      = int'(line_px) + int'(it.glyph_width);
        line_px = (px > int'(RUN_MAX)) ? RUN_MAX : RUN_W'(px);
        maxw    = int'(cfg_now.area_width) -
                  (cfg_now.scrollbar_on ? int'(cfg_now.scrollbar_width) : 0);
        if (int'(line_px) > maxw) begin
            if (word_run_on && space_on_line && int'(space_at) != p) begin
                line_px = (word_px > WORD_W'(RUN_MAX)) ? RUN_MAX : RUN_W'(word_px);
                brk     = int'(space_at) + 1;
            end else begin
                line_px = RUN_W'(it.glyph_width);
                brk     = p;
            end
            close_wrap_line(brk, brk);
            space_on_line = 1'b0;
            word_run_on   = 1'b0;
        end
        next_pos = POS_W'(p + 1);
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // scoreboard: predict on input transactions, compare output transactions
    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_wrap(i_in_data);
                if (drv_typed_n == 0) begin
                    foreach (fresh_records[k]) expected_records.push_back(fresh_records[k]);
                end else begin
                    expected_records.push_back(drv_typed0);
                    if (drv_typed_n == 2) expected_records.push_back(drv_typed1);
                end
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (expected_records.size() == 0) begin
                    report_mismatch($sformatf("record %h with nothing expected", got));
                end else begin
                    want = expected_records.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  got.kind, want.kind));
                    if (got.line_index != want.line_index)
                        report_mismatch($sformatf("line_index %0d, expected %0d",
                                                  got.line_index, want.line_index));
                    if (got.line_begin != want.line_begin)
                        report_mismatch($sformatf("line_begin %0d, expected %0d",
                                                  got.line_begin, want.line_begin));
                    if (got.line_end != want.line_end)
                        report_mismatch($sformatf("line_end %0d, expected %0d",
                                                  got.line_end, want.line_end));
                    if (got.total_lines != want.total_lines)
                        report_mismatch($sformatf("total_lines %0d, expected %0d",
                                                  got.total_lines, want.total_lines));
                    if (got.line_height != want.line_height)
                        report_mismatch($sformatf("line_height %0d, expected %0d",
                                                  got.line_height, want.line_height));
                    if (got.page_size != want.page_size)
                        report_mismatch($sformatf("page_size %0d, expected %0d",
                                                  got.page_size, want.page_size));
                    if (got.last != want.last)
                        report_mismatch($sformatf("last %0d, expected %0d",
                                                  got.last, want.last));
                end
            end
        end
    end

    // receiver: random stalls, a quiet stretch, and long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_item(t_in_item it, int n_typed, t_out_item t0, t_out_item t1);
        if (!steady && $urandom_range(0, 99) < 26) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 26);
        end
        i_in_valid  <= 1'b1;
        i_in_data   <= it;
        drv_typed_n <= n_typed;
        drv_typed0  <= t0;
        drv_typed1  <= t1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_records.size() != 0) @(posedge i_clk);
        // let the block settle before the next phase
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_AREA_WIDTH:      cfg_now.area_width      = val[CFG_W-1:0];
            REG_WINDOW_HEIGHT:   cfg_now.window_height   = val[CFG_W-1:0];
            REG_SCROLLBAR_ON:    cfg_now.scrollbar_on    = val[0];
            REG_SCROLLBAR_WIDTH: cfg_now.scrollbar_width = val[SBW_W-1:0];
            default: ;
        endcase
        // leave the bus idle before the next setup phase
        @(posedge i_clk);
    endtask

    task automatic set_config(int area, int win, int sb_on, int sbw);
        apb_write(REG_AREA_WIDTH, area);
        apb_write(REG_WINDOW_HEIGHT, win);
        apb_write(REG_SCROLLBAR_ON, sb_on);
        apb_write(REG_SCROLLBAR_WIDTH, sbw);
    endtask

    function automatic t_in_item char_item(logic op, int code, int gw, int gh);
        t_in_item it;
        it.op           = op;
        it.char_code    = CODE_W'(code);
        it.glyph_width  = GLYPH_W'(gw);
        it.glyph_height = GLYPH_W'(gh);
        return it;
    endfunction

    function automatic t_dir_row dir_row(logic op, int code, int gw, int gh);
        t_dir_row r;
        r.item    = char_item(op, code, gw, gh);
        r.n_typed = 0;
        r.typed0  = '0;
        r.typed1  = '0;
        return r;
    endfunction

    // Mostly words of ASCII letters between spaces, with some non-ASCII,
    // newlines, wide glyphs and an occasional finish.
    function automatic t_in_item random_item();
        int sel;
        int gw;
        int gh;
        sel = $urandom_range(0, 99);
        gw  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        gh  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        if (sel < 2)
            return char_item(OP_FINISH, $urandom_range(0, 65535), $urandom_range(0, 255),
                             $urandom_range(0, 255));
        if (sel < 17) return char_item(OP_CHAR, CODE_SPACE, $urandom_range(0, 12), gh);
        if (sel < 22) return char_item(OP_CHAR, CODE_NEWLINE, gw, gh);
        if (sel < 37) return char_item(OP_CHAR, $urandom_range(256, 65535), gw, gh);
        if (sel < 45) return char_item(OP_CHAR, $urandom_range(0, 255), gw, gh);
        return char_item(OP_CHAR, 16'h0061 + $urandom_range(0, 25), gw, gh);
    endfunction

    initial begin : stimulus
        t_in_item it;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        drv_typed_n = 0;
        drv_typed0  = '0;
        drv_typed1  = '0;
        mismatches  = 0;
        idle_cycles = 0;
        steady      = 1'b0;
        hold_asked  = 0;
        hold_served = 0;
        hold_left   = 0;
        cfg_now     = '{area_width: 12'd240, window_height: 12'd320,
                        scrollbar_on: 1'b1, scrollbar_width: 8'd8};
        wrap_clear();

        // reset config: usable width 232
        dir_table = '{
            dir_row(OP_FINISH, 16'h0000, 0, 0),     // nothing yet: one empty line
            dir_row(OP_CHAR, CODE_NEWLINE, 255, 255), // newline adds no size
            dir_row(OP_CHAR, 16'h0041, 255, 7),     // overflows alone
            dir_row(OP_CHAR, CODE_SPACE, 4, 0),
            dir_row(OP_CHAR, 16'h0077, 100, 20),
            dir_row(OP_CHAR, 16'h006F, 100, 20),
            dir_row(OP_CHAR, CODE_SPACE, 4, 0),
            dir_row(OP_CHAR, 16'h0072, 30, 0),      // break after the space
            dir_row(OP_CHAR, 16'h0000, 0, 0),       // code zero keeps the word run
            dir_row(OP_CHAR, 16'hFFFF, 255, 255),   // non-ASCII ends the run
            dir_row(OP_CHAR, 16'h0120, 10, 1),      // space only in the low byte
            dir_row(OP_CHAR, 16'h010A, 10, 1),      // newline only in the low byte
            dir_row(OP_CHAR, CODE_SPACE, 0, 0),
            dir_row(OP_CHAR, 16'h4E2D, 240, 3),     // non-ASCII after a space
            dir_row(OP_CHAR, CODE_NEWLINE, 0, 0),
            dir_row(OP_CHAR, 16'h0061, 120, 9),
            dir_row(OP_CHAR, 16'h0062, 120, 9),     // word with no space: cut here
            dir_row(OP_FINISH, 16'hFFFF, 255, 255),
            dir_row(OP_FINISH, 16'h0000, 0, 0)
        };
        dir_table[0].n_typed  = 2;
        dir_table[0].typed0   = line_record(0, 0, 0, 1'b0);
        dir_table[0].typed1   = summary_record(1, 2, 160);
        dir_table[1].n_typed  = 1;
        dir_table[1].typed0   = line_record(0, 0, 0, 1'b1);
        dir_table[18].n_typed = 2;
        dir_table[18].typed0  = line_record(0, 0, 0, 1'b0);
        dir_table[18].typed1  = summary_record(1, 2, 160);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++)
            send_item(dir_table[r].item, dir_table[r].n_typed,
                      dir_table[r].typed0, dir_table[r].typed1);
        drain_results();

        // scrollbar wider than the area: every character closes a line
        set_config(0, 4095, 1, 255);
        for (int n = 0; n < 30; n++) begin
            it = random_item();
            it.op = OP_CHAR;
            send_item(it, 0, '0, '0);
        end
        send_item(char_item(OP_FINISH, 0, 0, 0), 0, '0, '0);
        drain_results();

        // line limit: lines stop at MAX_LINES-1, later characters dropped
        set_config(4095, 0, 0, 0);
        for (int n = 0; n < MAX_LINES + 6; n++)
            send_item(char_item(OP_CHAR, CODE_NEWLINE, $urandom_range(0, 255), 0), 0, '0, '0);
        for (int n = 0; n < 3; n++)
            send_item(char_item(OP_CHAR, 16'h007A, 255, 200), 0, '0, '0);
        send_item(char_item(OP_FINISH, 0, 0, 0), 0, '0, '0);
        drain_results();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(120, 480),
                       $urandom_range(0, 4095), $urandom_range(0, 1),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 16));
            steady <= (ph == 2);
            if (ph == 5) begin
                // receiver holds off while newlines keep the output busy
                hold_asked <= hold_asked + 1;
                for (int n = 0; n < 12; n++)
                    send_item(char_item(OP_CHAR, CODE_NEWLINE, 0, 0), 0, '0, '0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item(), 0, '0, '0);
            send_item(char_item(OP_FINISH, 0, 0, 0), 0, '0, '0);
            drain_results();
        end

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/gww_pkg.sv
sv/gww_ctrl.sv
sv/gww_dp.sv
sv/greedy_word_wrap_line_breaker.sv
verif/greedy_word_wrap_line_breaker_tb.sv
